// ===== rtl/subset_min_pairwise_distance_top_assert.svh =====
// Assertion macros shared by the block's modules
`ifndef SUBSET_MIN_PAIRWISE_DISTANCE_TOP_ASSERT_SVH
`define SUBSET_MIN_PAIRWISE_DISTANCE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("never");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/smpd_pkg.sv =====
package smpd_pkg;
  localparam int MAX_ROWS = 1024;
  localparam int MAX_DIM = 8;
  localparam int MAX_SELECTED = 256;
  localparam int ROW_W = 10;
  localparam int DIM_W = 3;
  localparam int SEL_W = 8;
  localparam int CNT_W = 9;
  localparam int CRD_W = 24;
  localparam int SQ_W = 52;
  localparam int RES_W = 26;
  localparam int TAB_AW = ROW_W + DIM_W;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  typedef struct packed {
    logic       clr_min;
    logic       rd_a;
    logic       rd_b;
    logic       acc_clr;
    logic       acc_en;
    logic       pair_done;
    logic       sqrt_start;
  } smpd_cmd_t;

  typedef struct packed {
    logic sqrt_busy;
  } smpd_sts_t;
endpackage

// ===== rtl/smpd_ram.sv =====
module smpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/smpd_datapath.sv =====
`include "subset_min_pairwise_distance_top_assert.svh"
module smpd_datapath import smpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    tab_we,
  input  logic [TAB_AW-1:0]       tab_waddr,
  input  logic signed [CRD_W-1:0] tab_wdata,
  input  logic                    sel_we,
  input  logic [SEL_W-1:0]        sel_waddr,
  input  logic [ROW_W-1:0]        sel_wdata,
  input  logic [SEL_W-1:0]        sel_raddr,
  input  logic [DIM_W-1:0]        dim_sel,
  input  smpd_cmd_t               cmd,
  output smpd_sts_t               sts,
  output logic [RES_W-1:0]        root
);
  logic [ROW_W-1:0] sel_rdata, row_a_r, row_b_r;
  logic [TAB_AW-1:0] tab_raddr;
  logic signed [CRD_W-1:0] tab_rdata, ca_r;
  logic [CRD_W:0] ad;
  logic signed [CRD_W:0] d;
  logic [2*CRD_W+1:0] sq_r;
  logic sq_v_r;
  logic [SQ_W-1:0] acc_r, min_r;
  logic [SQ_W:0] sum;
  logic [SQ_W-1:0] rem_r;
  logic [RES_W-1:0] res_r;
  logic [4:0] step_r;
  logic busy_r;
  logic rd_a_q, rd_b_q;
  logic [RES_W-1:0] tbit, tval;
  logic [SQ_W-1:0] cand;

  smpd_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SELECTED)) u_sel (
    .clk, .we(sel_we), .waddr(sel_waddr), .wdata(sel_wdata),
    .raddr(sel_raddr), .rdata(sel_rdata));

  smpd_ram #(.WIDTH(CRD_W), .DEPTH(MAX_ROWS*MAX_DIM)) u_tab (
    .clk, .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata));

  assign tab_raddr = {cmd.rd_b ? row_b_r : row_a_r, dim_sel};

  always_ff @(posedge clk) begin
    if (cmd.pair_done) row_a_r <= sel_rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_a_q <= 1'b0; rd_b_q <= 1'b0; sq_v_r <= 1'b0;
    end else begin
      rd_a_q <= cmd.rd_a;
      rd_b_q <= cmd.rd_b;
      sq_v_r <= rd_b_q;
    end
    if (cmd.acc_clr) row_b_r <= sel_rdata;
    if (rd_a_q) ca_r <= tab_rdata;
    if (rd_b_q) sq_r <= (2*CRD_W+2)'(ad) * (2*CRD_W+2)'(ad);
  end

  assign d = {ca_r[CRD_W-1], ca_r} - {tab_rdata[CRD_W-1], tab_rdata};
  assign ad = d[CRD_W] ? (CRD_W+1)'(-d) : (CRD_W+1)'(d);
  assign sum = {1'b0, acc_r} + (SQ_W+1)'(sq_r);

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc_r <= '0;
    else if (sq_v_r) acc_r <= sum[SQ_W] ? '1 : sum[SQ_W-1:0];
    if (cmd.clr_min) min_r <= '1;
    else if (cmd.acc_en && acc_r < min_r) min_r <= acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; step_r <= '0;
    end else if (cmd.sqrt_start) begin
      busy_r <= 1'b1; step_r <= 5'(RES_W-1);
    end else if (busy_r) begin
      if (step_r == '0) busy_r <= 1'b0;
      step_r <= step_r - 5'd1;
    end
    if (cmd.sqrt_start) begin
      rem_r <= min_r; res_r <= '0;
    end else if (busy_r) begin
      if (cand <= rem_r) res_r <= tval;
    end
  end
  always_comb begin
    tbit = RES_W'(1) << step_r;
    tval = res_r | tbit;
    cand = SQ_W'(tval) * SQ_W'(tval);
  end

  assign sts.sqrt_busy = busy_r;
  assign root = res_r;

  `ASSERT_IMPL(a_sq_follows_rd, clk, rst_n, rd_b_q |=> sq_v_r)
  `ASSERT_IMPL(a_sqrt_idle_start, clk, rst_n, cmd.sqrt_start |-> !busy_r)
  `ASSERT_NEVER(a_no_rd_both, clk, rst_n, cmd.rd_a && cmd.rd_b)
endmodule

// ===== rtl/smpd_ctrl.sv =====
`include "subset_min_pairwise_distance_top_assert.svh"
module smpd_ctrl import smpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic             in_last_select,
  input  logic [3:0]       dims,
  output logic             sel_we,
  output logic [SEL_W-1:0] sel_waddr,
  output logic [SEL_W-1:0] sel_raddr,
  output logic [DIM_W-1:0] dim_sel,
  output smpd_cmd_t        cmd,
  input  smpd_sts_t        sts,
  output logic             res_load,
  output logic             res_few,
  output logic             res_ovf,
  input  logic             out_busy
);
  localparam logic [3:0] S_IDLE = 4'd0, S_LDA = 4'd1, S_LDB = 4'd2, S_DA = 4'd3,
    S_DB = 4'd4, S_DRAIN = 4'd5, S_NEXT = 4'd6, S_SQRT = 4'd7, S_SQW = 4'd8,
    S_OUT = 4'd9, S_LDA2 = 4'd10;
  logic [3:0] state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [DIM_W:0] k_r, k_nxt, nd;
  logic [2:0] dr_r, dr_nxt;
  logic few_r, few_nxt;
  logic acc;

  assign nd = (dims > 4'(MAX_DIM)) ? (DIM_W+1)'(MAX_DIM) : dims;
  assign acc = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign sel_we = acc && in_req_type == REQ_SELECT && cnt_r < CNT_W'(MAX_SELECTED);
  assign sel_waddr = cnt_r[SEL_W-1:0];
  assign dim_sel = k_r[DIM_W-1:0];

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r; i_nxt = i_r; j_nxt = j_r;
    k_nxt = k_r; dr_nxt = dr_r; few_nxt = few_r;
    cmd = '0; sel_raddr = i_r[SEL_W-1:0]; res_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_req_type == REQ_SELECT) begin
          if (sel_we) cnt_nxt = cnt_r + 1'b1;
          else ovf_nxt = 1'b1;
          if (in_last_select) begin
            few_nxt = cnt_nxt < CNT_W'(2);
            cmd.clr_min = 1'b1;
            i_nxt = '0;
            state_nxt = few_nxt ? S_OUT : S_LDA;
          end
        end
      end
      S_LDA: begin
        sel_raddr = i_r[SEL_W-1:0]; j_nxt = i_r + 1'b1; state_nxt = S_LDA2;
      end
      S_LDA2: begin
        cmd.pair_done = 1'b1; sel_raddr = j_r[SEL_W-1:0]; state_nxt = S_LDB;
      end
      S_LDB: begin
        cmd.acc_clr = 1'b1; k_nxt = '0;
        state_nxt = (nd == '0) ? S_DRAIN : S_DA; dr_nxt = '0;
      end
      S_DA: begin cmd.rd_a = 1'b1; state_nxt = S_DB; end
      S_DB: begin
        cmd.rd_b = 1'b1; k_nxt = k_r + 1'b1;
        state_nxt = (k_nxt == nd) ? S_DRAIN : S_DA;
      end
      S_DRAIN: begin
        dr_nxt = dr_r + 1'b1;
        if (dr_r == 3'd3) state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.acc_en = 1'b1;
        if (j_r + 1'b1 < cnt_r) begin
          j_nxt = j_r + 1'b1; sel_raddr = j_nxt[SEL_W-1:0]; state_nxt = S_LDB;
        end else if (i_r + CNT_W'(2) < cnt_r) begin
          i_nxt = i_r + 1'b1; state_nxt = S_LDA;
        end else state_nxt = S_SQRT;
      end
      S_SQRT: begin cmd.sqrt_start = 1'b1; state_nxt = S_SQW; end
      S_SQW: if (!sts.sqrt_busy) state_nxt = S_OUT;
      S_OUT: begin
        if (!out_busy) begin
          res_load = 1'b1; cnt_nxt = '0; ovf_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_few = few_r;
  assign res_ovf = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; ovf_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; dr_r <= dr_nxt; few_r <= few_nxt;
  end

  `ASSERT_IMPL(a_cnt_cap, clk, rst_n, cnt_r <= CNT_W'(MAX_SELECTED))
  `ASSERT_IMPL(a_res_clr, clk, rst_n, res_load |=> cnt_r == '0 && !ovf_r)
  `ASSERT_IMPL(a_stall_busy, clk, rst_n, state_r != S_IDLE |-> in_stall)
endmodule

// ===== rtl/subset_min_pairwise_distance_top.sv =====
// channel | ports                               | beat
// in      | in_valid in_stall in_req_type ...   | one load or select
// out     | out_valid out_stall out_min_distance| one search result
// cfg     | cfg_we cfg_wdata                    | dims_used
// Load and select beats are accepted back to back while in_stall is low.
// The last select runs the pair search through one point-table read port, unless
// fewer than two rows are selected, reading both rows of each pair dimension by
// dimension; a 26-step bit-serial square root then feeds the output register.
// Synchronous active-low reset; input stalls from the last select until the
// result is in the output register.
module subset_min_pairwise_distance_top import smpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [3:0]              cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [ROW_W-1:0]        in_row_index,
  input  logic [DIM_W-1:0]        in_dim_index,
  input  logic signed [CRD_W-1:0] in_coord_value,
  input  logic                    in_last_select,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [RES_W-1:0]        out_min_distance,
  output logic                    out_too_few,
  output logic                    out_list_overflow
);
  logic [3:0] dims_r;
  logic sel_we, res_load, res_few, res_ovf, tab_we;
  logic [SEL_W-1:0] sel_waddr, sel_raddr;
  logic [DIM_W-1:0] dim_sel;
  logic [RES_W-1:0] root;
  smpd_cmd_t cmd;
  smpd_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) dims_r <= 4'd8;
    else if (cfg_we) dims_r <= cfg_wdata;
  end

  assign tab_we = in_valid && !in_stall && in_req_type == REQ_LOAD;

  smpd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_last_select,
    .dims(dims_r), .sel_we, .sel_waddr, .sel_raddr, .dim_sel, .cmd, .sts,
    .res_load, .res_few, .res_ovf, .out_busy(out_valid && out_stall));

  smpd_datapath u_dp (
    .clk, .rst_n, .tab_we, .tab_waddr({in_row_index, in_dim_index}),
    .tab_wdata(in_coord_value), .sel_we, .sel_waddr, .sel_wdata(in_row_index),
    .sel_raddr, .dim_sel, .cmd, .sts, .root);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (res_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (res_load) begin
      out_min_distance <= res_few ? '0 : root;
      out_too_few <= res_few;
      out_list_overflow <= res_ovf;
    end
  end
endmodule

// ===== bench/tb_subset_min_pairwise_distance_top.sv =====
module tb_subset_min_pairwise_distance_top;
  import smpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                    req_type;
    logic [ROW_W-1:0]        row_index;
    logic [DIM_W-1:0]        dim_index;
    logic signed [CRD_W-1:0] coord_value;
    logic                    last_select;
  } beat_t;

  typedef struct {
    logic [RES_W-1:0] min_distance;
    logic             too_few;
    logic             list_overflow;
  } dist_result_t;

  localparam longint unsigned SQ_SAT = (64'd1 << SQ_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = 1'b0;
  logic [ROW_W-1:0] in_row_index = '0;
  logic [DIM_W-1:0] in_dim_index = '0;
  logic signed [CRD_W-1:0] in_coord_value = '0;
  logic in_last_select = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RES_W-1:0] out_min_distance;
  logic out_too_few;
  logic out_list_overflow;

  beat_t        pending_beats[$];
  dist_result_t expected_results[$];
  int           fail_count = 0;
  longint       cycle_count = 0;

  logic signed [CRD_W-1:0] point_mem[MAX_ROWS][MAX_DIM];
  logic [ROW_W-1:0]        sel_rows[$];
  logic                    sel_overflow = 1'b0;
  logic [3:0]              dims_reg = 4'd8;

  logic [7:0]       gen_mask[MAX_ROWS];
  logic [ROW_W-1:0] full_rows[$];
  int               gen_items = 0;

  int in_gap = 0;
  int out_hold = 0;

  subset_min_pairwise_distance_top u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_row_index(in_row_index), .in_dim_index(in_dim_index),
    .in_coord_value(in_coord_value), .in_last_select(in_last_select),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_min_distance(out_min_distance), .out_too_few(out_too_few),
    .out_list_overflow(out_list_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned pair_sq_dist(logic [ROW_W-1:0] a, logic [ROW_W-1:0] b,
                                                   int nd);
    longint unsigned s, ad;
    longint d;
    s = 0;
    for (int k = 0; k < nd; k++) begin
      d = longint'(point_mem[a][k]) - longint'(point_mem[b][k]);
      ad = (d < 0) ? -d : d;
      s = s + ad * ad;
      if (s > SQ_SAT) s = SQ_SAT;
    end
    return s;
  endfunction

  task automatic predict_beat(beat_t b);
    dist_result_t r;
    longint unsigned best, s;
    int nd;
    if (b.req_type == REQ_LOAD) begin
      point_mem[b.row_index][b.dim_index] = b.coord_value;
      return;
    end
    if (sel_rows.size() < MAX_SELECTED) sel_rows.insert(sel_rows.size(), b.row_index);
    else sel_overflow = 1'b1;
    if (!b.last_select) return;
    nd = (dims_reg > MAX_DIM) ? MAX_DIM : dims_reg;
    best = SQ_SAT;
    r.too_few = sel_rows.size() < 2;
    r.min_distance = '0;
    if (!r.too_few) begin
      for (int i = 0; i < sel_rows.size(); i++)
        for (int j = i + 1; j < sel_rows.size(); j++) begin
          s = pair_sq_dist(sel_rows[i], sel_rows[j], nd);
          if (s < best) best = s;
        end
      r.min_distance = RES_W'(floor_sqrt(best));
    end
    r.list_overflow = sel_overflow;
    expected_results.insert(expected_results.size(), r);
    sel_rows.delete();
    sel_overflow = 1'b0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    beat_t b;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        b.req_type = in_req_type;
        b.row_index = in_row_index;
        b.dim_index = in_dim_index;
        b.coord_value = in_coord_value;
        b.last_select = in_last_select;
        predict_beat(b);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          b = pending_beats.pop_front();
          in_req_type <= b.req_type;
          in_row_index <= b.row_index;
          in_dim_index <= b.dim_index;
          in_coord_value <= b.coord_value;
          in_last_select <= b.last_select;
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    dist_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_min_distance, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_min_distance !== e.min_distance)
            report_mismatch("min_distance", out_min_distance, e.min_distance);
          if (out_too_few !== e.too_few)
            report_mismatch("too_few", out_too_few, e.too_few);
          if (out_list_overflow !== e.list_overflow)
            report_mismatch("list_overflow", out_list_overflow, e.list_overflow);
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        out_hold <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_beat(logic rt, logic [ROW_W-1:0] row, logic [DIM_W-1:0] dim,
                          logic signed [CRD_W-1:0] val, logic last);
    beat_t b;
    b.req_type = rt;
    b.row_index = row;
    b.dim_index = dim;
    b.coord_value = val;
    b.last_select = last;
    if (rt == REQ_LOAD) begin
      gen_mask[row][dim] = 1'b1;
      if (gen_mask[row] == 8'hff) begin
        if (!(row inside {full_rows})) full_rows.insert(full_rows.size(), row);
      end
    end
    pending_beats.insert(pending_beats.size(), b);
    gen_items++;
  endtask

  task automatic load_row(logic [ROW_W-1:0] row, int spread);
    logic signed [CRD_W-1:0] v;
    for (int k = 0; k < MAX_DIM; k++) begin
      if (spread == 0) v = CRD_W'($urandom);
      else v = CRD_W'($signed($urandom_range(0, 2 * spread)) - spread);
      add_beat(REQ_LOAD, row, DIM_W'(k), v, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_dims(logic [3:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    dims_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n, spread;
    logic [3:0] dims_list[$];
    dims_list = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6, 4'd8};
    for (int r = 0; r < MAX_ROWS; r++) gen_mask[r] = 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < MAX_DIM; k++)
      add_beat(REQ_LOAD, 10'd0, DIM_W'(k), 24'sh7fffff, 1'b0);
    for (int k = 0; k < MAX_DIM; k++)
      add_beat(REQ_LOAD, 10'd1023, DIM_W'(k), -24'sh800000, 1'b1);
    add_beat(REQ_SELECT, 10'd0, 3'd0, 24'sd0, 1'b0);
    add_beat(REQ_SELECT, 10'd1023, 3'd7, -24'sd1, 1'b1);
    add_beat(REQ_SELECT, 10'd0, 3'd0, 24'sd0, 1'b1);
    add_beat(REQ_SELECT, 10'd1023, 3'd0, 24'sd0, 1'b0);
    add_beat(REQ_SELECT, 10'd1023, 3'd0, 24'sd0, 1'b1);
    add_beat(REQ_SELECT, 10'd0, 3'd0, 24'sd0, 1'b0);
    add_beat(REQ_SELECT, 10'd1023, 3'd0, 24'sd0, 1'b0);
    add_beat(REQ_SELECT, 10'd0, 3'd0, 24'sd0, 1'b1);
    wait_idle();

    foreach (dims_list[p]) begin
      set_dims(dims_list[p]);
      while (gen_items < 65 * (p + 1)) begin
        spread = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2000);
        for (int r = 0; r < 3; r++)
          load_row(ROW_W'($urandom_range(0, MAX_ROWS - 1)), spread);
        add_beat(REQ_LOAD, ROW_W'($urandom_range(0, MAX_ROWS - 1)),
                 DIM_W'($urandom_range(0, 7)), CRD_W'($urandom), 1'b0);
        for (int q = 0; q < 3; q++) begin
          n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
          for (int s = 0; s < n; s++)
            add_beat(REQ_SELECT, full_rows[$urandom_range(0, full_rows.size() - 1)],
                     DIM_W'($urandom_range(0, 7)), CRD_W'($urandom), s == n - 1);
        end
      end
      wait_idle();
    end

    set_dims(4'd1);
    for (int s = 0; s < MAX_SELECTED + 3; s++)
      add_beat(REQ_SELECT, full_rows[$urandom_range(0, full_rows.size() - 1)],
               3'd0, 24'sd0, s == MAX_SELECTED + 2);
    add_beat(REQ_SELECT, full_rows[0], 3'd0, 24'sd0, 1'b0);
    add_beat(REQ_SELECT, full_rows[1], 3'd0, 24'sd0, 1'b1);
    wait_idle();
    repeat (100) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
